// ----- rtl/nqpt_pkg.sv -----
// Package for the queue pair tracker: widths, status codes, item types.
// No dependencies.
`timescale 1ns / 1ps

package nqpt_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int RING_W   = 12;
  localparam int LEN_W    = 13;
  localparam int MAX_RING = 4096;
  localparam int HANDLE_W = 16;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [31:0] DOORBELL_BASE = 32'h0000_1000;

  typedef enum logic [2:0] {
    ST_SUBMITTED = 3'd0,
    ST_NO_SLOT   = 3'd1,
    ST_RING_FULL = 3'd2,
    ST_CONSUMED  = 3'd3,
    ST_NOT_READY = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SQ_LENGTH    = 3'd0,
    REG_CQ_LENGTH    = 3'd1,
    REG_SLOT_COUNT   = 3'd2,
    REG_QUEUE_NUMBER = 3'd3,
    REG_STRIDE_CODE  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                mode;
    logic [HANDLE_W-1:0] cmd_handle;
    logic                cq_phase;
    logic [HANDLE_W-1:0] cq_cmd_id;
    logic [RING_W-1:0]   cq_sq_head;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [5:0]          cmd_id;
    logic [RING_W-1:0]   sq_write_index;
    logic [RING_W-1:0]   sq_new_tail;
    logic [31:0]         doorbell_address;
    logic [HANDLE_W-1:0] done_handle;
    logic [RING_W-1:0]   cq_head_now;
    logic                phase_now;
  } out_item_t;

  // Classified work handed from front to back.
  typedef struct packed {
    logic                mode;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic                id_ok;
    logic                phase_ok;
    logic [HANDLE_W-1:0] handle;
    logic [RING_W-1:0]   sq_head_in;
  } work_t;

endpackage

// ----- rtl/nqpt_if.sv -----
// Valid/ready channel interface carrying one item type.
// Depends on nqpt_pkg.
`timescale 1ns / 1ps

interface nqpt_in_if;
  import nqpt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nqpt_out_if;
  import nqpt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/nqpt_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module nqpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/nqpt_front.sv -----
// Front end: accepts items, searches free slots, checks ids and phase.
// Depends on nqpt_pkg. Busy bits live in the back end and are seen here.
`timescale 1ns / 1ps

module nqpt_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  nqpt_pkg::in_item_t      in_data,
  input  logic [nqpt_pkg::SLOTS-1:0] busy,
  input  logic [nqpt_pkg::SLOT_W:0]  eff_n,
  input  logic [nqpt_pkg::SLOT_W-1:0] search_start,
  input  logic                    expected_phase,
  input  logic                    back_idle,
  output logic                    work_valid,
  output nqpt_pkg::work_t         work
);
  import nqpt_pkg::*;

  logic [SLOTS-1:0]  free_mask;
  logic [SLOT_W-1:0] start;
  logic              found_hi, found_lo;
  logic [SLOT_W-1:0] pos_hi, pos_lo;
  logic [HANDLE_W-1:0] cid;

  // One item in flight: accept only when front and back are both empty.
  assign in_ready = !work_valid && back_idle;

  assign start = ({1'b0, search_start} < eff_n) ? search_start : '0;

  // Rotating priority search: first free at or above start, else lowest free.
  always_comb begin
    found_hi = 1'b0;
    found_lo = 1'b0;
    pos_hi   = '0;
    pos_lo   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      free_mask[i] = !busy[i] && (i < int'(eff_n));
      if (free_mask[i]) begin
        found_lo = 1'b1;
        pos_lo   = SLOT_W'(i);
        if (SLOT_W'(i) >= start) begin
          found_hi = 1'b1;
          pos_hi   = SLOT_W'(i);
        end
      end
    end
  end

  assign cid = in_data.cq_cmd_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      work_valid <= 1'b1;
    end else begin
      work_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      work.mode       <= in_data.mode;
      work.found      <= found_lo;
      work.slot       <= in_data.mode ? cid[SLOT_W-1:0] : (found_hi ? pos_hi : pos_lo);
      work.id_ok      <= (cid < HANDLE_W'(eff_n)) && busy[cid[SLOT_W-1:0]];
      work.phase_ok   <= in_data.cq_phase == expected_phase;
      work.handle     <= in_data.cmd_handle;
      work.sq_head_in <= in_data.cq_sq_head;
    end
  end
endmodule

// ----- rtl/nqpt_back.sv -----
// Back end: updates slot table and ring pointers, builds the result beat.
// Depends on nqpt_pkg and nqpt_ram.
`timescale 1ns / 1ps

module nqpt_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    work_valid,
  input  nqpt_pkg::work_t         work,
  input  logic [nqpt_pkg::LEN_W-1:0] sq_length,
  input  logic [nqpt_pkg::LEN_W-1:0] cq_length,
  input  logic [9:0]              queue_number,
  input  logic [3:0]              stride_code,
  output logic [nqpt_pkg::SLOTS-1:0] busy,
  output logic [nqpt_pkg::SLOT_W-1:0] search_start,
  output logic                    expected_phase,
  output logic                    back_idle,
  output logic                    out_valid,
  input  logic                    out_ready,
  output nqpt_pkg::out_item_t     out_data
);
  import nqpt_pkg::*;

  logic [RING_W-1:0] sq_head, sq_tail, cq_head;
  logic [LEN_W-1:0]  slen, clen;
  logic [LEN_W-1:0]  tail_inc, cq_inc;
  logic [RING_W-1:0] next_tail, cq_head_next;
  logic              wrap;
  logic [HANDLE_W-1:0] rd_handle;
  logic              pend;       // result waiting on the RAM read
  out_item_t         res, res_next, out_next;
  logic [31:0]       dbell;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    if (v < LEN_W'(2))        return LEN_W'(2);
    if (v > LEN_W'(MAX_RING)) return LEN_W'(MAX_RING);
    return v;
  endfunction

  assign slen      = clamp_len(sq_length);
  assign clen      = clamp_len(cq_length);
  assign tail_inc  = {1'b0, sq_tail} + LEN_W'(1);
  assign next_tail = (tail_inc >= slen) ? '0 : tail_inc[RING_W-1:0];
  assign cq_inc    = {1'b0, cq_head} + LEN_W'(1);
  assign wrap      = cq_inc >= clen;
  assign cq_head_next = wrap ? '0 : cq_inc[RING_W-1:0];
  // 2*q*(1<<(code+2)) = q << (code+3)
  assign dbell = DOORBELL_BASE + (32'(queue_number) << (32'(stride_code) + 32'd3));

  logic do_sub, do_cpl;
  assign do_sub = work_valid && !work.mode && work.found && (sq_head != next_tail);
  assign do_cpl = work_valid && work.mode && work.phase_ok && work.id_ok;

  nqpt_ram #(.WIDTH(HANDLE_W), .DEPTH(SLOTS)) u_handles (
    .clk   (clk),
    .we    (do_sub),
    .waddr (work.slot),
    .wdata (work.handle),
    .raddr (work.slot),
    .rdata (rd_handle)
  );

  assign back_idle = !pend && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= '0;
      search_start   <= '0;
      sq_head        <= '0;
      sq_tail        <= '0;
      cq_head        <= '0;
      expected_phase <= 1'b1;
      pend           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (pend) begin
        pend      <= 1'b0;
        out_valid <= 1'b1;
      end
      if (work_valid) begin
        pend <= 1'b1;
        if (!work.mode && work.found && !do_sub) search_start <= work.slot;
        if (do_sub) begin
          busy[work.slot] <= 1'b1;
          sq_tail         <= next_tail;
        end
        if (do_cpl) begin
          busy[work.slot] <= 1'b0;
          sq_head         <= work.sq_head_in;
          cq_head         <= cq_head_next;
          if (wrap) expected_phase <= !expected_phase;
        end
      end
    end
  end

  // Result fields: old state, plus the new tail, CQ head and phase
  always_comb begin
    res_next = '0;
    if (!work.mode) begin
      if (!work.found) begin
        res_next.status = ST_NO_SLOT;
      end else if (!do_sub) begin
        res_next.status = ST_RING_FULL;
        res_next.cmd_id = 6'(work.slot);
      end else begin
        res_next.status           = ST_SUBMITTED;
        res_next.cmd_id           = 6'(work.slot);
        res_next.sq_write_index   = sq_tail;
        res_next.sq_new_tail      = next_tail;
        res_next.doorbell_address = dbell;
      end
      res_next.cq_head_now = cq_head;
      res_next.phase_now   = expected_phase;
    end else if (!work.phase_ok) begin
      res_next.status      = ST_NOT_READY;
      res_next.cq_head_now = cq_head;
      res_next.phase_now   = expected_phase;
    end else if (!work.id_ok) begin
      res_next.status      = ST_UNKNOWN;
      res_next.cq_head_now = cq_head;
      res_next.phase_now   = expected_phase;
    end else begin
      res_next.status      = ST_CONSUMED;
      res_next.cmd_id      = 6'(work.slot);
      res_next.cq_head_now = cq_head_next;
      res_next.phase_now   = wrap ? !expected_phase : expected_phase;
    end
  end

  // Handle joins the result when RAM data lands
  always_comb begin
    out_next = res;
    if (res.status == ST_CONSUMED) out_next.done_handle = rd_handle;
  end

  // Build the result in res, then register it with the handle into out_data
  always_ff @(posedge clk) begin
    if (work_valid) res <= res_next;
    if (pend) out_data <= out_next;
  end
endmodule

// ----- rtl/nvme_queue_pair_tracker.sv -----
// Top level of the queue pair tracker: config registers, front and back.
// Depends on nqpt_pkg, nqpt_if, nqpt_front, nqpt_back.
`timescale 1ns / 1ps

// Tracks one submission/completion ring pair. Each input beat gives exactly
// one result beat. One item is in flight at a time: the front registers the
// slot search and checks, the back updates state and reads the handle RAM,
// and the result register then presents the beat. The next item is accepted
// only after the result has been taken, so a receiver that stalls holds off
// the next accept. Config registers must be written only while no item is in
// flight.

module nvme_queue_pair_tracker (
  input  logic                  clk,
  input  logic                  rst,
  nqpt_in_if.sink               in_ch,
  nqpt_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [nqpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nqpt_pkg::CFG_W-1:0]     cfg_data
);
  import nqpt_pkg::*;

  logic [LEN_W-1:0] sq_length, cq_length;
  logic [6:0]       slot_count;
  logic [9:0]       queue_number;
  logic [3:0]       stride_code;
  logic [SLOT_W:0]  eff_n;

  logic [SLOTS-1:0]  busy;
  logic [SLOT_W-1:0] search_start;
  logic              expected_phase, back_idle, work_valid;
  work_t             work;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_length    <= LEN_W'(32);
      cq_length    <= LEN_W'(32);
      slot_count   <= 7'd32;
      queue_number <= '0;
      stride_code  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SQ_LENGTH:    sq_length    <= cfg_data;
        REG_CQ_LENGTH:    cq_length    <= cfg_data;
        REG_SLOT_COUNT:   slot_count   <= cfg_data[6:0];
        REG_QUEUE_NUMBER: queue_number <= cfg_data[9:0];
        REG_STRIDE_CODE:  stride_code  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign eff_n = (slot_count == 7'd0) ? (SLOT_W+1)'(1) :
                 (slot_count > 7'(SLOTS)) ? (SLOT_W+1)'(SLOTS) : slot_count[SLOT_W:0];

  nqpt_front u_front (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data),
    .busy, .eff_n, .search_start, .expected_phase, .back_idle,
    .work_valid, .work
  );

  nqpt_back u_back (
    .clk, .rst, .work_valid, .work,
    .sq_length, .cq_length, .queue_number, .stride_code,
    .busy, .search_start, .expected_phase, .back_idle,
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );
endmodule

// ----- rtl/nqpt_checker.sv -----
// Port-level checker for the tracker, bound to the top level.
// Depends on nqpt_pkg and the channel interfaces.
`timescale 1ns / 1ps

module nqpt_checker (
  input logic              clk,
  input logic              rst,
  nqpt_in_if.sink          in_ch,
  nqpt_out_if.source       out_ch
);
  import nqpt_pkg::*;

  // No input is taken while a result beat is waiting.
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("accept while result pending");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped");

  // Every accepted beat yields a result.
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |-> ##3 out_ch.valid) else $error("missing result");

  // Status codes stay in the defined set.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.data.status <= 3'(ST_UNKNOWN)) else $error("bad status");
endmodule

bind nvme_queue_pair_tracker nqpt_checker u_nqpt_checker (
  .clk (clk), .rst (rst), .in_ch (in_ch), .out_ch (out_ch)
);
